### hdl/photometric_profile_lookup_assert.svh
// ----------------------------------------------------------------------------
// photometric profile lookup assertion macros
// shared property forms for the lookup block checks
// ----------------------------------------------------------------------------
`ifndef PHOTOMETRIC_PROFILE_LOOKUP_ASSERT_SVH
`define PHOTOMETRIC_PROFILE_LOOKUP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PPL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ppl check failed");

// next-cycle implication, checked outside reset
`define PPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ppl check failed");

`endif

### hdl/ppl_pkg.sv
// ----------------------------------------------------------------------------
// ppl_pkg
// types and constants shared by the photometric profile lookup block
// ----------------------------------------------------------------------------
package ppl_pkg;

    localparam int ANG_W  = 18;  // table and query angle width
    localparam int SA_W   = 19;  // folded angle width
    localparam int IDX_W  = 14;  // write index width
    localparam int CAND_W = 32;  // candela width
    localparam int CNT_W  = 8;   // count register width
    localparam int CFG_W  = 2;   // config index width
    localparam int FRAC_W = 16;  // interval fraction width
    localparam int NUM_W  = 21;  // divider operand width
    localparam int MA_W   = 34;  // multiplier operand a
    localparam int MB_W   = 18;  // multiplier operand b
    localparam int MP_W   = MA_W + MB_W;

    // angles in 1/64 degree
    localparam logic signed [SA_W-1:0] DEG_N90 = -19'sd5760;
    localparam logic signed [SA_W-1:0] DEG_0   = 19'sd0;
    localparam logic signed [SA_W-1:0] DEG_90  = 19'sd5760;
    localparam logic signed [SA_W-1:0] DEG_180 = 19'sd11520;
    localparam logic signed [SA_W-1:0] DEG_270 = 19'sd17280;
    localparam logic signed [SA_W-1:0] DEG_360 = 19'sd23040;
    localparam logic signed [SA_W-1:0] DEG_540 = 19'sd34560;

    typedef enum logic [1:0] {
        CMD_WR_VERT  = 2'd0,
        CMD_WR_HORIZ = 2'd1,
        CMD_WR_CAND  = 2'd2,
        CMD_LOOKUP   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_W-1:0] {
        CFG_VCOUNT = 2'd0,
        CFG_HCOUNT = 2'd1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_WRAP, S_FIRST, S_LAST, S_FOLD,
        S_SCAN0, S_SCAN_RD, S_SCAN_CMP, S_DIV, S_AXIS,
        S_MA, S_MB, S_R0, S_R1, S_R2, S_R3, S_R4,
        S_L0, S_L1, S_L2, S_L3, S_L4, S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### hdl/ppl_ram.sv
// ----------------------------------------------------------------------------
// ppl_ram
// generic simple dual-port ram, one write port, registered read
// ----------------------------------------------------------------------------
module ppl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ppl_frac_div.sv
// ----------------------------------------------------------------------------
// ppl_frac_div
// restoring divider, one quotient bit a cycle, num < den gives q0.16
// ----------------------------------------------------------------------------
module ppl_frac_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ppl_pkg::NUM_W-1:0]     i_num,
    input  logic [ppl_pkg::NUM_W-1:0]     i_den,
    output ppl_pkg::t_div_stat            o_stat,
    output logic [ppl_pkg::FRAC_W-1:0]    o_quot
);
    import ppl_pkg::*;

    localparam int CW = $clog2(FRAC_W + 1);

    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_den;
    logic [FRAC_W-1:0] r_quot;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [NUM_W:0]    w_shift;
    logic              w_ge;

    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(FRAC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? NUM_W'(w_shift - {1'b0, r_den}) : NUM_W'(w_shift);
            r_quot <= {r_quot[FRAC_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

### hdl/photometric_profile_lookup.sv
// ----------------------------------------------------------------------------
// photometric_profile_lookup
// candela profile store with wrapped, folded bilinear lookup
// ----------------------------------------------------------------------------
//  channel  direction  signals                                    moves
//  cfg      in         i_cfg_valid/o_cfg_ready, index, data       count register write
//  in       in         i_in_valid/o_in_ready, command + fields    table write or lookup
//  out      out        o_out_valid/i_out_ready, o_intensity       one result per lookup
//
//  a table write lands on its transfer; a lookup's time is set by the serial interval
//  scan (a read state and a compare state per table angle on the read port) and the
//  16-step fraction divider, each run at most once per axis
//  reset clears the counts, the sequencer and the output valid flag; tables are not cleared
//  no transfer on the in channel while a lookup runs; a finished result waits in the
//  output register, and table writes are taken while it waits
// ----------------------------------------------------------------------------
module photometric_profile_lookup #(
    parameter int MAX_VERTICAL_ANGLES   = 128,
    parameter int MAX_HORIZONTAL_ANGLES = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ppl_pkg::CFG_W-1:0]         i_cfg_index,
    input  logic [ppl_pkg::CNT_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_command,
    input  logic [ppl_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [ppl_pkg::ANG_W-1:0]  i_angle_value,
    input  logic [ppl_pkg::CAND_W-1:0]        i_candela_value,
    input  logic signed [ppl_pkg::ANG_W-1:0]  i_query_horizontal,
    input  logic signed [ppl_pkg::ANG_W-1:0]  i_query_vertical,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ppl_pkg::CAND_W-1:0]        o_intensity
);
    import ppl_pkg::*;
    `include "photometric_profile_lookup_assert.svh"

    localparam int GDEPTH = MAX_VERTICAL_ANGLES * MAX_HORIZONTAL_ANGLES;
    localparam int VA = $clog2(MAX_VERTICAL_ANGLES);
    localparam int HA = $clog2(MAX_HORIZONTAL_ANGLES);
    localparam int GA = $clog2(GDEPTH);
    localparam int VN = $clog2(MAX_VERTICAL_ANGLES + 1);
    localparam int HN = $clog2(MAX_HORIZONTAL_ANGLES + 1);
    localparam int NW = (VN > HN) ? VN : HN;

    // state and registers
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_vcount, r_hcount;
    logic signed [SA_W-1:0] r_h, r_v, r_s, r_first, r_prev, r_hf, r_vf;
    logic [NW-1:0] r_n, r_i, r_idx, r_h0, r_v0;
    logic [FRAC_W-1:0] r_frac, r_fh, r_fv;
    logic r_axis;  // 0 horizontal scan, 1 vertical scan
    logic [GA-1:0] r_base0, r_base1;
    logic signed [MA_W-1:0] r_c00, r_c10, r_c01, r_c11, r_c0, r_c1;
    logic signed [MP_W-1:0] r_prod;
    logic [CAND_W-1:0] r_res, r_out;
    logic r_out_valid;

    // clamped counts
    logic [NW-1:0] w_nv, w_nh, w_h1, w_v1;
    assign w_nv = (32'(r_vcount) > MAX_VERTICAL_ANGLES) ? NW'(MAX_VERTICAL_ANGLES)
                                                         : NW'(r_vcount);
    assign w_nh = (32'(r_hcount) > MAX_HORIZONTAL_ANGLES) ? NW'(MAX_HORIZONTAL_ANGLES)
                                                           : NW'(r_hcount);
    assign w_h1 = ((r_h0 + 1'b1) < w_nh) ? NW'(r_h0 + 1'b1) : NW'(w_nh - 1'b1);
    assign w_v1 = ((r_v0 + 1'b1) < w_nv) ? NW'(r_v0 + 1'b1) : NW'(w_nv - 1'b1);

    // input transfers
    logic w_in_xfer, w_lookup;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_lookup    = w_in_xfer && (t_cmd'(i_command) == CMD_LOOKUP);
    assign o_cfg_ready = 1'b1;

    // table memories
    logic [31:0] w_idx32;
    logic w_we_v, w_we_h, w_we_g;
    logic [VA-1:0] w_ra_v;
    logic [HA-1:0] w_ra_h;
    logic [GA-1:0] w_ra_g;
    logic [ANG_W-1:0] w_rd_v, w_rd_h;
    logic [CAND_W-1:0] w_rd_g;

    assign w_idx32 = 32'(i_entry_index);
    assign w_we_v  = w_in_xfer && (t_cmd'(i_command) == CMD_WR_VERT)
                     && (w_idx32 < MAX_VERTICAL_ANGLES);
    assign w_we_h  = w_in_xfer && (t_cmd'(i_command) == CMD_WR_HORIZ)
                     && (w_idx32 < MAX_HORIZONTAL_ANGLES);
    assign w_we_g  = w_in_xfer && (t_cmd'(i_command) == CMD_WR_CAND)
                     && (w_idx32 < GDEPTH);

    ppl_ram #(.WIDTH(ANG_W), .DEPTH(MAX_VERTICAL_ANGLES)) u_vert_tab (
        .i_clk(i_clk), .i_we(w_we_v), .i_waddr(w_idx32[VA-1:0]),
        .i_wdata(i_angle_value), .i_raddr(w_ra_v), .o_rdata(w_rd_v)
    );
    ppl_ram #(.WIDTH(ANG_W), .DEPTH(MAX_HORIZONTAL_ANGLES)) u_horiz_tab (
        .i_clk(i_clk), .i_we(w_we_h), .i_waddr(w_idx32[HA-1:0]),
        .i_wdata(i_angle_value), .i_raddr(w_ra_h), .o_rdata(w_rd_h)
    );
    ppl_ram #(.WIDTH(CAND_W), .DEPTH(GDEPTH)) u_cand_grid (
        .i_clk(i_clk), .i_we(w_we_g), .i_waddr(w_idx32[GA-1:0]),
        .i_wdata(i_candela_value), .i_raddr(w_ra_g), .o_rdata(w_rd_g)
    );

    logic signed [SA_W-1:0] w_tv, w_th, w_tax;
    assign w_tv  = SA_W'(signed'(w_rd_v));
    assign w_th  = SA_W'(signed'(w_rd_h));
    assign w_tax = r_axis ? w_tv : w_th;

    // symmetry fold and half-sphere test, on the first and last table angles
    logic signed [SA_W-1:0] w_hfold, w_vfold;
    logic w_vzero;
    always_comb begin
        w_hfold = r_h;
        w_vfold = r_v;
        w_vzero = 1'b0;
        if (r_hf == DEG_0 && w_th == DEG_90) begin
            if (w_hfold > DEG_90 && w_hfold < DEG_180) begin
                w_hfold = DEG_180 - w_hfold;
            end else if (w_hfold >= DEG_180 && w_hfold < DEG_270) begin
                w_hfold = DEG_540 - w_hfold;
            end
            if (w_hfold >= DEG_270) begin
                w_hfold = DEG_360 - w_hfold;
            end
        end else if (r_hf == DEG_0 && w_th == DEG_180) begin
            if (w_hfold >= DEG_180) begin
                w_hfold = DEG_360 - w_hfold;
            end
        end else if (r_hf == DEG_90 && w_th == DEG_270) begin
            if (w_hfold < DEG_90) begin
                w_hfold = DEG_180 - w_hfold;
            end else if (w_hfold >= DEG_270) begin
                w_hfold = DEG_540 - w_hfold;
            end
        end else if (r_hf == DEG_N90 && w_th == DEG_90) begin
            if (w_hfold >= DEG_180) begin
                w_hfold = DEG_360 - w_hfold;
            end
            w_hfold = w_hfold - DEG_90;
        end
        if (r_vf == DEG_0 && w_tv == DEG_90) begin
            w_vzero = (r_v > DEG_90);
        end else if (r_vf == DEG_90 && w_tv == DEG_180) begin
            w_vzero = (r_v < DEG_90);
        end else if (r_vf == DEG_N90 && w_tv == DEG_90) begin
            w_vfold = r_v - DEG_90;
        end else if (w_nv == NW'(1)) begin
            w_vfold = r_vf;
        end
    end

    // interval compare and fraction divider
    logic w_lt;
    logic w_div_start;
    logic [NUM_W-1:0] w_num, w_den;
    t_div_stat w_div;
    logic [FRAC_W-1:0] w_quot;

    assign w_lt  = r_s < w_tax;
    assign w_num = NUM_W'(r_s - r_prev);
    assign w_den = NUM_W'(w_tax - r_prev);

    ppl_frac_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_num), .i_den(w_den), .o_stat(w_div), .o_quot(w_quot)
    );

    // shared multiplier operands
    logic signed [MA_W-1:0] w_ma;
    logic signed [MB_W-1:0] w_mb;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (w_lookup) n_state = S_WRAP;
            S_WRAP:     if (r_h >= DEG_0 && r_h < DEG_360) n_state = S_FIRST;
            S_FIRST:    n_state = (w_nh == '0 || w_nv == '0) ? S_OUT : S_LAST;
            S_LAST:     n_state = S_FOLD;
            S_FOLD:     n_state = w_vzero ? S_OUT : S_SCAN0;
            S_SCAN0:    n_state = (r_n <= NW'(1) || r_s <= r_first) ? S_AXIS : S_SCAN_RD;
            S_SCAN_RD:  n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (w_lt) begin
                    n_state = S_DIV;
                end else if (r_i == NW'(r_n - 1'b1)) begin
                    n_state = S_AXIS;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_DIV:      if (w_div.done) n_state = S_AXIS;
            S_AXIS:     n_state = r_axis ? S_MA : S_SCAN0;
            S_MA:       n_state = S_MB;
            S_MB:       n_state = S_R0;
            S_R0:       n_state = S_R1;
            S_R1:       n_state = S_R2;
            S_R2:       n_state = S_R3;
            S_R3:       n_state = S_R4;
            S_R4:       n_state = S_L0;
            S_L0:       n_state = S_L1;
            S_L1:       n_state = S_L2;
            S_L2:       n_state = S_L3;
            S_L3:       n_state = S_L4;
            S_L4:       n_state = S_OUT;
            S_OUT:      if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: read addresses, divider start, multiplier operands
    always_comb begin
        w_ra_v      = '0;
        w_ra_h      = '0;
        w_ra_g      = r_base0 + GA'(r_v0);
        w_div_start = 1'b0;
        w_ma        = MA_W'(r_h0);
        w_mb        = MB_W'(w_nv);
        case (r_state)
            S_LAST: begin
                w_ra_v = VA'(w_nv - 1'b1);
                w_ra_h = HA'(w_nh - 1'b1);
            end
            S_SCAN_RD: begin
                w_ra_v = VA'(r_i);
                w_ra_h = HA'(r_i);
            end
            S_SCAN_CMP: w_div_start = w_lt;
            S_MB:       w_ma = MA_W'(w_h1);
            S_R1:       w_ra_g = r_base1 + GA'(r_v0);
            S_R2:       w_ra_g = r_base0 + GA'(w_v1);
            S_R3:       w_ra_g = r_base1 + GA'(w_v1);
            S_L0: begin
                w_ma = r_c10 - r_c00;
                w_mb = MB_W'(r_fh);
            end
            S_L1: begin
                w_ma = r_c11 - r_c01;
                w_mb = MB_W'(r_fh);
            end
            S_L3: begin
                w_ma = r_c1 - r_c0;
                w_mb = MB_W'(r_fv);
            end
            default: begin
                w_ra_v = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= '0;
            r_hcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (t_cfg_idx'(i_cfg_index) == CFG_VCOUNT) r_vcount <= i_cfg_data;
                else if (t_cfg_idx'(i_cfg_index) == CFG_HCOUNT) r_hcount <= i_cfg_data;
            end
            if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        case (r_state)
            S_IDLE: begin
                r_h <= SA_W'(i_query_horizontal);
                r_v <= SA_W'(i_query_vertical);
                r_res <= '0;
            end
            S_WRAP: begin
                // bring h into 0..360 degrees, one step of 360 a cycle
                if (r_h < DEG_0) r_h <= r_h + DEG_360;
                else if (r_h >= DEG_360) r_h <= r_h - DEG_360;
            end
            S_LAST: begin
                r_hf <= w_th;
                r_vf <= w_tv;
            end
            S_FOLD: begin
                r_v     <= w_vfold;
                r_s     <= w_hfold;
                r_n     <= w_nh;
                r_first <= r_hf;
                r_axis  <= 1'b0;
            end
            S_SCAN0: begin
                r_idx  <= '0;
                r_frac <= '0;
                r_prev <= r_first;
                r_i    <= NW'(1);
            end
            S_SCAN_CMP: begin
                if (w_lt) begin
                    r_idx <= NW'(r_i - 1'b1);
                end else begin
                    r_prev <= w_tax;
                    r_i    <= NW'(r_i + 1'b1);
                    r_idx  <= NW'(r_n - 1'b1);
                    r_frac <= '0;
                end
            end
            S_DIV: if (w_div.done) r_frac <= w_quot;
            S_AXIS: begin
                if (r_axis) begin
                    r_v0 <= r_idx;
                    r_fv <= r_frac;
                end else begin
                    r_h0    <= r_idx;
                    r_fh    <= r_frac;
                    r_axis  <= 1'b1;
                    r_s     <= r_v;
                    r_first <= r_vf;
                    r_n     <= w_nv;
                end
            end
            S_MB: r_base0 <= r_prod[GA-1:0];
            S_R0: r_base1 <= r_prod[GA-1:0];
            S_R1: r_c00 <= MA_W'(w_rd_g);
            S_R2: r_c10 <= MA_W'(w_rd_g);
            S_R3: r_c01 <= MA_W'(w_rd_g);
            S_R4: r_c11 <= MA_W'(w_rd_g);
            // floor of the product over 2^16 is an arithmetic shift
            S_L1: r_c0 <= r_c00 + MA_W'(r_prod >>> FRAC_W);
            S_L2: r_c1 <= r_c01 + MA_W'(r_prod >>> FRAC_W);
            S_L4: r_res <= CAND_W'(r_c0 + MA_W'(r_prod >>> FRAC_W));
            S_OUT: if (!r_out_valid || i_out_ready) r_out <= r_res;
            default: r_res <= r_res;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_intensity = r_out;

    // a lookup holds the input side until its result is parked
    `PPL_ASSERT_NEXT(a_lookup_blocks_in, w_lookup, !o_in_ready)
    // divider only started from the scan compare, never while busy
    `PPL_ASSERT_NOW(a_div_start_idle, w_div_start, !w_div.busy && r_state == S_SCAN_CMP)
    // leaving the output state always leaves a result in the register
    `PPL_ASSERT_NEXT(a_out_loaded, r_state == S_OUT && (!r_out_valid || i_out_ready),
                     o_out_valid)
    // table writes never land during a lookup
    `PPL_ASSERT_NOW(a_write_idle, w_we_v || w_we_h || w_we_g, r_state == S_IDLE)

endmodule

### test/photometric_profile_lookup_checker.sv
// ----------------------------------------------------------------------------
// photometric profile lookup checker
// tracks table and count writes, predicts each lookup result and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module photometric_profile_lookup_checker #(
    parameter int MAX_V = 128,
    parameter int MAX_H = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [ppl_pkg::CFG_W-1:0]         i_cfg_index,
    input  logic [ppl_pkg::CNT_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [1:0]                        i_command,
    input  logic [ppl_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [ppl_pkg::ANG_W-1:0]  i_angle_value,
    input  logic [ppl_pkg::CAND_W-1:0]        i_candela_value,
    input  logic signed [ppl_pkg::ANG_W-1:0]  i_query_horizontal,
    input  logic signed [ppl_pkg::ANG_W-1:0]  i_query_vertical,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [ppl_pkg::CAND_W-1:0]        i_intensity,
    output int                                o_failures,
    output int                                o_pending
);
    import ppl_pkg::*;

    int            vert_angle [MAX_V];
    int            horiz_angle[MAX_H];
    logic [31:0]   candela    [MAX_V*MAX_H];
    int            vert_count;
    int            horiz_count;
    logic [31:0]   intensity_q[$];

    // interval search on one axis, fraction in q0.16
    function automatic int scan_axis(bit vert, int n, int s, output longint frac);
        int lo;
        int hi;
        frac = 0;
        if (n <= 1) return 0;
        lo = vert ? vert_angle[0] : horiz_angle[0];
        if (s <= lo) return 0;
        for (int i = 1; i < n; i++) begin
            hi = vert ? vert_angle[i] : horiz_angle[i];
            lo = vert ? vert_angle[i-1] : horiz_angle[i-1];
            if (s < hi) begin
                if (hi > lo) frac = ((longint'(s) - lo) * 65536) / (longint'(hi) - lo);
                return i - 1;
            end
        end
        return n - 1;
    endfunction

    // linear step with floored product
    function automatic longint blend(longint a, longint b, longint f);
        longint p;
        p = (b - a) * f;
        if (p >= 0) return a + p / 65536;
        return a - ((-p + 65535) / 65536);
    endfunction

    function automatic logic [31:0] predict_intensity(int qh, int qv);
        int     nh, nv, h, v, hf, hl, vf, vl, h0, h1, v0, v1;
        longint fh, fv, c0, c1;
        nh = (horiz_count > MAX_H) ? MAX_H : horiz_count;
        nv = (vert_count > MAX_V) ? MAX_V : vert_count;
        if (nh == 0 || nv == 0) return '0;
        h = qh % int'(DEG_360);
        if (h < 0) h += int'(DEG_360);
        hf = horiz_angle[0];
        hl = horiz_angle[nh-1];
        // horizontal symmetry folds
        if (hf == int'(DEG_0) && hl == int'(DEG_90)) begin
            if (h > int'(DEG_90) && h < int'(DEG_180)) h = int'(DEG_180) - h;
            else if (h >= int'(DEG_180) && h < int'(DEG_270)) h = int'(DEG_540) - h;
            if (h >= int'(DEG_270)) h = int'(DEG_360) - h;
        end else if (hf == int'(DEG_0) && hl == int'(DEG_180)) begin
            if (h >= int'(DEG_180)) h = int'(DEG_360) - h;
        end else if (hf == int'(DEG_90) && hl == int'(DEG_270)) begin
            if (h < int'(DEG_90)) h = int'(DEG_180) - h;
            else if (h >= int'(DEG_270)) h = int'(DEG_540) - h;
        end else if (hf == int'(DEG_N90) && hl == int'(DEG_90)) begin
            if (h >= int'(DEG_180)) h = int'(DEG_360) - h;
            h -= int'(DEG_90);
        end
        v = qv;
        vf = vert_angle[0];
        vl = vert_angle[nv-1];
        // half-sphere vertical profiles
        if (vf == int'(DEG_0) && vl == int'(DEG_90)) begin
            if (v > int'(DEG_90)) return '0;
        end else if (vf == int'(DEG_90) && vl == int'(DEG_180)) begin
            if (v < int'(DEG_90)) return '0;
        end else if (vf == int'(DEG_N90) && vl == int'(DEG_90)) begin
            v -= int'(DEG_90);
        end else if (nv == 1) begin
            v = vf;
        end
        h0 = scan_axis(1'b0, nh, h, fh);
        v0 = scan_axis(1'b1, nv, v, fv);
        h1 = (h0 + 1 < nh) ? h0 + 1 : nh - 1;
        v1 = (v0 + 1 < nv) ? v0 + 1 : nv - 1;
        c0 = blend(candela[h0*nv+v0], candela[h1*nv+v0], fh);
        c1 = blend(candela[h0*nv+v1], candela[h1*nv+v1], fh);
        return 32'(blend(c0, c1, fv));
    endfunction

    assign o_pending = intensity_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vert_count  <= 0;
            horiz_count <= 0;
            o_failures  <= 0;
            intensity_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_VCOUNT: vert_count  <= int'(i_cfg_data);
                    CFG_HCOUNT: horiz_count <= int'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (intensity_q.size() == 0) begin
                    $display("%0t: unexpected intensity %h", $time, i_intensity);
                    o_failures <= o_failures + 1;
                end else begin
                    if (i_intensity !== intensity_q[0]) begin
                        $display("%0t: intensity expected %h actual %h",
                                 $time, intensity_q[0], i_intensity);
                        o_failures <= o_failures + 1;
                    end
                    void'(intensity_q.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (t_cmd'(i_command))
                    CMD_WR_VERT:
                        if (i_entry_index < MAX_V) vert_angle[i_entry_index] = i_angle_value;
                    CMD_WR_HORIZ:
                        if (i_entry_index < MAX_H) horiz_angle[i_entry_index] = i_angle_value;
                    CMD_WR_CAND:
                        if (i_entry_index < MAX_V*MAX_H) candela[i_entry_index] = i_candela_value;
                    CMD_LOOKUP:
                        intensity_q.push_back(predict_intensity(i_query_horizontal,
                                                                i_query_vertical));
                    default: ;
                endcase
            end
        end
    end

endmodule

### test/photometric_profile_lookup_tb.sv
// ----------------------------------------------------------------------------
// photometric profile lookup testbench
// loads profiles of many shapes and sizes, then fires directed and random
// lookups mixed with table writes under bursty input and stalling output
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module photometric_profile_lookup_tb;
    import ppl_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int HOLD_START   = 3000;   // cycle at which the long output stall begins
    localparam int HOLD_CYCLES  = 5000;
    localparam int ITEM_TARGET  = 1300;

    // angle spans a profile table can cover
    typedef enum int {
        SPAN_0_90, SPAN_0_180, SPAN_90_180, SPAN_90_270, SPAN_N90_90, SPAN_FREE
    } t_span;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_W-1:0]         i_cfg_index;
    logic [CNT_W-1:0]         i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [1:0]               i_command;
    logic [IDX_W-1:0]         i_entry_index;
    logic signed [ANG_W-1:0]  i_angle_value;
    logic [CAND_W-1:0]        i_candela_value;
    logic signed [ANG_W-1:0]  i_query_horizontal;
    logic signed [ANG_W-1:0]  i_query_vertical;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [CAND_W-1:0]        o_intensity;

    int failures;
    int pending;
    int cycles = 0;
    int items_sent;
    int burst_left;
    bit gaps_on;
    int hold_left = 0;
    int stall_left = 0;
    int stall_mode = 0;

    photometric_profile_lookup dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_entry_index      (i_entry_index),
        .i_angle_value      (i_angle_value),
        .i_candela_value    (i_candela_value),
        .i_query_horizontal (i_query_horizontal),
        .i_query_vertical   (i_query_vertical),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_intensity        (o_intensity)
    );

    photometric_profile_lookup_checker chk (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_entry_index      (i_entry_index),
        .i_angle_value      (i_angle_value),
        .i_candela_value    (i_candela_value),
        .i_query_horizontal (i_query_horizontal),
        .i_query_vertical   (i_query_vertical),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_intensity        (o_intensity),
        .o_failures         (failures),
        .o_pending          (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output side: one long hold to back the block up, otherwise shifting stall patterns
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (cycles == HOLD_START) begin
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(16, 200);
            end
            stall_left = stall_left - 1;
            case (stall_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= $urandom_range(0, 1);
                default: i_out_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // one transfer on the input channel; gaps come between bursts when gaps are on
    task automatic send_item(t_cmd cmd, int idx, int ang, logic [31:0] cand, int qh, int qv);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
        i_command          <= cmd;
        i_entry_index      <= idx[IDX_W-1:0];
        i_angle_value      <= ang[ANG_W-1:0];
        i_candela_value    <= cand;
        i_query_horizontal <= qh[ANG_W-1:0];
        i_query_vertical   <= qv[ANG_W-1:0];
        i_in_valid         <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left = burst_left - 1;
        items_sent = items_sent + 1;
    endtask

    task automatic write_count(t_cfg_idx idx, int value);
        i_cfg_index <= idx;
        i_cfg_data  <= value[CNT_W-1:0];
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain all lookups, then let any trailing write settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // fill one angle table evenly across a span, with some repeated neighbours
    task automatic load_angles(t_cmd cmd, int n, t_span span);
        int a, b, val, prev;
        case (span)
            SPAN_0_90:   begin a = 0;     b = 5760;  end
            SPAN_0_180:  begin a = 0;     b = 11520; end
            SPAN_90_180: begin a = 5760;  b = 11520; end
            SPAN_90_270: begin a = 5760;  b = 17280; end
            SPAN_N90_90: begin a = -5760; b = 5760;  end
            default: begin
                a = -int'($urandom_range(0, 8000));
                b = a + int'($urandom_range(0, 20000));
            end
        endcase
        prev = a;
        for (int i = 0; i < n; i++) begin
            val = (n == 1) ? a : a + (b - a) * i / (n - 1);
            if (i > 0 && i < n - 1 && $urandom_range(0, 5) == 0) val = prev;
            prev = val;
            send_item(cmd, i, val, $urandom, $urandom, $urandom);
        end
    endtask

    function automatic logic [31:0] pick_candela();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // one profile setting: counts, tables, optional directed probes, then a random mix
    task automatic run_profile(int vc, int hc, t_span vspan, t_span hspan, int n_random,
                               bit probes);
        int nv, nh, cells, sel, qh, qv;
        wait_idle();
        gaps_on = ($urandom_range(0, 3) != 0);
        write_count(CFG_VCOUNT, vc);
        write_count(CFG_HCOUNT, hc);
        nv = (vc > 128) ? 128 : vc;
        nh = (hc > 128) ? 128 : hc;
        cells = nv * nh;
        if (nv > 0) load_angles(CMD_WR_VERT, nv, vspan);
        if (nh > 0) load_angles(CMD_WR_HORIZ, nh, hspan);
        for (int i = 0; i < cells; i++)
            send_item(CMD_WR_CAND, i, $urandom, pick_candela(), $urandom, $urandom);
        if (probes) begin
            // wrap edges, symmetry boundaries and field extremes
            for (int i = 0; i < 8; i++) begin
                case (i)
                    0: begin qh = 0;       qv = 0;       end
                    1: begin qh = -131072; qv = 131071;  end
                    2: begin qh = 131071;  qv = -131072; end
                    3: begin qh = 5760;    qv = 5760;    end
                    4: begin qh = 11520;   qv = 11520;   end
                    5: begin qh = 17280;   qv = -5760;   end
                    6: begin qh = 23040;   qv = 5761;    end
                    default: begin qh = -5760; qv = 5759; end
                endcase
                send_item(CMD_LOOKUP, $urandom, $urandom, $urandom, qh, qv);
            end
        end
        for (int i = 0; i < n_random; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                if ($urandom_range(0, 9) < 7) begin
                    qh = $urandom_range(0, 51200) - 25600;
                    qv = $urandom_range(0, 18000) - 6000;
                end else begin
                    qh = $urandom;
                    qv = $urandom;
                end
                send_item(CMD_LOOKUP, $urandom, $urandom, $urandom, qh, qv);
            end else if (sel < 70 && cells > 0) begin
                send_item(CMD_WR_CAND, $urandom_range(0, cells - 1), $urandom,
                          pick_candela(), $urandom, $urandom);
            end else if (sel < 80) begin
                // interior rewrites keep the end angles, others land unused or out of range
                if (nv > 2 && $urandom_range(0, 1) == 0)
                    send_item(CMD_WR_VERT, $urandom_range(1, nv - 2),
                              $urandom_range(0, 12000) - 6000, $urandom, $urandom, $urandom);
                else
                    send_item(CMD_WR_VERT, $urandom_range(nv, 16383), $urandom,
                              $urandom, $urandom, $urandom);
            end else if (sel < 90) begin
                if (nh > 2 && $urandom_range(0, 1) == 0)
                    send_item(CMD_WR_HORIZ, $urandom_range(1, nh - 2),
                              $urandom_range(0, 23040) - 5760, $urandom, $urandom, $urandom);
                else
                    send_item(CMD_WR_HORIZ, $urandom_range(nh, 16383), $urandom,
                              $urandom, $urandom, $urandom);
            end else begin
                // candela writes outside the active grid
                send_item(CMD_WR_CAND, $urandom_range(cells, 16383), $urandom,
                          $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = CFG_VCOUNT;
        i_cfg_data         = '0;
        i_in_valid         = 1'b0;
        i_command          = CMD_LOOKUP;
        i_entry_index      = '0;
        i_angle_value      = '0;
        i_candela_value    = '0;
        i_query_horizontal = '0;
        i_query_vertical   = '0;
        items_sent         = 0;
        burst_left         = 0;
        gaps_on            = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero counts straight out of reset
        run_profile(0, 0, SPAN_FREE, SPAN_FREE, 10, 1'b1);
        run_profile(2, 2, SPAN_0_90, SPAN_0_90, 60, 1'b1);
        run_profile(3, 4, SPAN_90_180, SPAN_0_180, 60, 1'b1);
        run_profile(4, 3, SPAN_N90_90, SPAN_90_270, 60, 1'b0);
        run_profile(5, 5, SPAN_FREE, SPAN_N90_90, 60, 1'b0);
        run_profile(1, 6, SPAN_FREE, SPAN_FREE, 50, 1'b0);
        // counts beyond capacity on one axis at a time
        run_profile(255, 1, SPAN_0_90, SPAN_FREE, 40, 1'b0);
        run_profile(1, 200, SPAN_FREE, SPAN_0_180, 40, 1'b0);
        run_profile(6, 0, SPAN_FREE, SPAN_FREE, 20, 1'b0);
        run_profile(0, 5, SPAN_FREE, SPAN_FREE, 20, 1'b0);
        run_profile(7, 7, SPAN_FREE, SPAN_FREE, 60, 1'b0);
        while (items_sent < ITEM_TARGET)
            run_profile($urandom_range(1, 8), $urandom_range(1, 8),
                        t_span'($urandom_range(0, 5)), t_span'($urandom_range(0, 5)),
                        60, 1'b0);
        wait_idle();

        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
